### src/assert_macros.svh
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define BMH_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion on the local clock and reset
`define BMH_ASSERT(lbl, prop, msg) \
   `BMH_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

### src/bmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg
// request codes and controller state type of the min-heap queue
// ----------------------------------------------------------------------------
package bmh_pkg;

   localparam logic [1:0] REQ_PUSH  = 2'd0;
   localparam logic [1:0] REQ_POP   = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_PU_CMP = 9'b000000010,
      ST_PU_FIN = 9'b000000100,
      ST_PO_LST = 9'b000001000,
      ST_DN_RDL = 9'b000010000,
      ST_DN_RDR = 9'b000100000,
      ST_DN_CMP = 9'b001000000,
      ST_DONE   = 9'b010000000,
      ST_SPARE  = 9'b100000000
   } state_type;

endpackage

### src/bmh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh request and response channels
// valid/ready channels carrying heap requests and heap reports
// ----------------------------------------------------------------------------
interface bmh_req_if #(
   parameter int COORD_BITS = 16,
   parameter int KEY_BITS   = 32
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            req_type;
   logic [COORD_BITS-1:0] cell_x;
   logic [COORD_BITS-1:0] cell_y;
   logic [KEY_BITS-1:0]   key_primary;
   logic [KEY_BITS-1:0]   key_secondary;

   modport source (output valid, req_type, cell_x, cell_y, key_primary, key_secondary,
                   input ready);
   modport sink   (input valid, req_type, cell_x, cell_y, key_primary, key_secondary,
                   output ready);
endinterface

interface bmh_rsp_if #(
   parameter int COORD_BITS = 16,
   parameter int KEY_BITS   = 32,
   parameter int CNT_BITS   = 11
);
   logic                  valid;
   logic                  ready;
   logic                  has_entry;
   logic [COORD_BITS-1:0] out_x;
   logic [COORD_BITS-1:0] out_y;
   logic [KEY_BITS-1:0]   out_key_primary;
   logic [KEY_BITS-1:0]   out_key_secondary;
   logic [CNT_BITS-1:0]   entry_count;
   logic                  overflow;

   modport source (output valid, has_entry, out_x, out_y, out_key_primary,
                   out_key_secondary, entry_count, overflow, input ready);
   modport sink   (input valid, has_entry, out_x, out_y, out_key_primary,
                   out_key_secondary, entry_count, overflow, output ready);
endinterface

### src/bmh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ram
// heap slot storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bmh_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### src/binary_min_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue
// array heap of grid cells ordered by a two-part key, smallest on top
// ----------------------------------------------------------------------------
// req_chan takes push, pop-min and clear requests; rsp_chan returns one
// report per request: the popped entry (pop) or the current top (push,
// clear), the entry count after the request and an overflow flag when a
// push meets a full heap and is dropped.
// All slots sit in one single-port-read, single-port-write RAM with
// registered read data; a copy of the root is kept in a register.
// Clear, empty pop and full push go straight to the done state. A push
// compares the new entry with one parent per level climbed (up to log2
// of CAPACITY), moving each larger parent down, and writes it where it
// stops. A pop moves the last entry to the root and descends level by
// level, each level being a left child read, a right child read and a
// compare/write.
// One request is in flight at a time; a finished report waits in the
// output register while ready is low, and the next request is taken once
// the engine is idle. Reset empties the heap at once (no clearing pass).
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue #(
   parameter int CAPACITY   = 1024,
   parameter int COORD_BITS = 16,
   parameter int KEY_BITS   = 32
) (
   input logic     clock,
   input logic     reset,
   bmh_req_if.sink   req_chan,
   bmh_rsp_if.source rsp_chan
);
   import bmh_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = IDX_W + 2;
   localparam int ENT_W = 2 * COORD_BITS + 2 * KEY_BITS;
   localparam int KY_W  = 2 * KEY_BITS;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [ENT_W-1:0]     cur_ff, cur_in;
   logic [ENT_W-1:0]     top_ff;
   logic [ENT_W-1:0]     left_ff, left_in;
   logic                 rvld_ff, rvld_in;
   logic [ENT_W-1:0]     popped_ff, popped_in;
   logic                 is_pop_ff, is_pop_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff;
   logic [ENT_W-1:0]     rsp_ent_ff;
   logic                 rsp_has_ff;
   logic [CNT_W-1:0]     rsp_cnt_ff;
   logic                 rsp_ovf_ff;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENT_W-1:0]     wr_data;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENT_W-1:0]     rd_data;

   logic                 req_fire;
   logic                 rsp_free;
   logic [EXT_W-1:0]     count_ext;
   logic [EXT_W-1:0]     left_ext;
   logic [EXT_W-1:0]     right_ext;
   logic [IDX_W-1:0]     parent;
   logic [CNT_W-1:0]     cnt_dec;
   logic                 less_left;
   logic                 less_right;
   logic [KY_W-1:0]      best_key;
   logic [ENT_W-1:0]     new_ent;

   bmh_ram #(.DEPTH(CAPACITY), .WIDTH(ENT_W)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // handshake and index arithmetic
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign count_ext      = EXT_W'(count_ff);
   assign left_ext       = {1'b0, idx_ff, 1'b1};
   assign right_ext      = {1'b0, idx_ff, 1'b0} + EXT_W'(2);
   assign parent         = IDX_W'((idx_ff - 1'b1) >> 1);
   assign cnt_dec        = count_ff - 1'b1;
   assign new_ent        = {req_chan.cell_x, req_chan.cell_y,
                            req_chan.key_primary, req_chan.key_secondary};

   // child compares: strict less, left wins ties
   assign less_left  = left_ff[KY_W-1:0] < cur_ff[KY_W-1:0];
   assign best_key   = less_left ? left_ff[KY_W-1:0] : cur_ff[KY_W-1:0];
   assign less_right = rvld_ff && (rd_data[KY_W-1:0] < best_key);

   // controller
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      cur_in    = cur_ff;
      left_in   = left_ff;
      rvld_in   = rvld_ff;
      popped_in = popped_ff;
      is_pop_in = is_pop_ff;
      ovf_in    = ovf_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = cur_ff;
      rd_addr   = parent;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               is_pop_in = 1'b0;
               ovf_in    = 1'b0;
               state_in  = ST_DONE;
               case (req_chan.req_type)
                  REQ_PUSH: begin
                     if (count_ext >= EXT_W'(CAPACITY)) begin
                        ovf_in = 1'b1;
                     end else begin
                        cur_in   = new_ent;
                        idx_in   = count_ff[IDX_W-1:0];
                        count_in = count_ff + 1'b1;
                        if (count_ff == '0) begin
                           wr_en   = 1'b1;
                           wr_addr = '0;
                           wr_data = new_ent;
                        end else begin
                           rd_addr  = IDX_W'(cnt_dec >> 1);
                           state_in = ST_PU_CMP;
                        end
                     end
                  end
                  REQ_POP: begin
                     if (count_ff != '0) begin
                        is_pop_in = 1'b1;
                        popped_in = top_ff;
                        count_in  = cnt_dec;
                        if (cnt_dec != '0) begin
                           rd_addr  = cnt_dec[IDX_W-1:0];
                           state_in = ST_PO_LST;
                        end
                     end
                  end
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PU_CMP: begin
            // rd_data holds the parent of idx
            if (cur_ff[KY_W-1:0] < rd_data[KY_W-1:0]) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               idx_in  = parent;
               if (parent == '0) begin
                  state_in = ST_PU_FIN;
               end else begin
                  rd_addr = IDX_W'((parent - 1'b1) >> 1);
               end
            end else begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_PU_FIN: begin
            wr_en    = 1'b1;
            state_in = ST_DONE;
         end
         ST_PO_LST: begin
            // last entry moves to the root
            cur_in   = rd_data;
            idx_in   = '0;
            state_in = ST_DN_RDL;
         end
         ST_DN_RDL: begin
            if (left_ext < count_ext) begin
               rd_addr  = left_ext[IDX_W-1:0];
               state_in = ST_DN_RDR;
            end else begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DN_RDR: begin
            left_in  = rd_data;
            rvld_in  = right_ext < count_ext;
            rd_addr  = right_ext[IDX_W-1:0];
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (less_right) begin
               wr_data  = rd_data;
               idx_in   = right_ext[IDX_W-1:0];
               state_in = ST_DN_RDL;
            end else if (less_left) begin
               wr_data  = left_ff;
               idx_in   = left_ext[IDX_W-1:0];
               state_in = ST_DN_RDL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers, root copy follows every write to slot zero
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      cur_ff    <= cur_in;
      left_ff   <= left_in;
      rvld_ff   <= rvld_in;
      popped_ff <= popped_in;
      is_pop_ff <= is_pop_in;
      ovf_ff    <= ovf_in;
      if (wr_en && (wr_addr == '0)) begin
         top_ff <= wr_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_cnt_ff <= count_ff;
         rsp_ovf_ff <= ovf_ff;
         if (is_pop_ff) begin
            rsp_has_ff <= 1'b1;
            rsp_ent_ff <= popped_ff;
         end else begin
            rsp_has_ff <= (count_ff != '0);
            rsp_ent_ff <= (count_ff != '0) ? top_ff : '0;
         end
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.has_entry         = rsp_has_ff;
   assign rsp_chan.out_x             = rsp_ent_ff[ENT_W-1 -: COORD_BITS];
   assign rsp_chan.out_y             = rsp_ent_ff[KY_W+COORD_BITS-1 -: COORD_BITS];
   assign rsp_chan.out_key_primary   = rsp_ent_ff[KY_W-1 -: KEY_BITS];
   assign rsp_chan.out_key_secondary = rsp_ent_ff[KEY_BITS-1:0];
   assign rsp_chan.entry_count       = rsp_cnt_ff;
   assign rsp_chan.overflow          = rsp_ovf_ff;
endmodule

### src/bmh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_checker
// port-level checks on the heap response channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmh_checker #(
   parameter int CAPACITY   = 1024,
   parameter int COORD_BITS = 16,
   parameter int KEY_BITS   = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          has_entry,
   input logic [COORD_BITS-1:0]         out_x,
   input logic [KEY_BITS-1:0]           out_key_primary,
   input logic [$clog2(CAPACITY+1)-1:0] entry_count,
   input logic                          overflow
);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // a stalled response stays up
   `BMH_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped")

   // count never passes capacity
   `BMH_ASSERT(a_cnt_max, rsp_valid |-> entry_count <= CNT_W'(CAPACITY), "count too big")

   // an overflow is only reported on a full heap with a top
   `BMH_ASSERT(a_ovf_full, rsp_valid && overflow |-> has_entry && (entry_count == CNT_W'(CAPACITY)), "bad overflow")

   // empty report carries zero fields
   `BMH_ASSERT(a_empty_zero, rsp_valid && !has_entry |-> (out_x == '0) && (out_key_primary == '0), "empty not zero")
endmodule

bind binary_min_heap_priority_queue bmh_checker #(
   .CAPACITY   (CAPACITY),
   .COORD_BITS (COORD_BITS),
   .KEY_BITS   (KEY_BITS)
) u_bmh_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .has_entry       (rsp_chan.has_entry),
   .out_x           (rsp_chan.out_x),
   .out_key_primary (rsp_chan.out_key_primary),
   .entry_count     (rsp_chan.entry_count),
   .overflow        (rsp_chan.overflow)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the min-heap priority queue
// ----------------------------------------------------------------------------
// a queue of pending requests feeds a clocked driver; a clocked monitor
// compares each report with a heap model kept in the bench. the run steps
// through several idling phases, builds a deeper heap and drains it, and
// holds the response side off to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
   import bmh_pkg::*;

   localparam int CAP       = 1024;
   localparam int MAX_CYCLE = 1500000;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] cell_x;
      logic [15:0] cell_y;
      logic [31:0] key_primary;
      logic [31:0] key_secondary;
   } heap_req_t;

   typedef struct packed {
      logic        has_entry;
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic [31:0] out_key_primary;
      logic [31:0] out_key_secondary;
      logic [10:0] entry_count;
      logic        overflow;
   } heap_rpt_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmh_req_if #(.COORD_BITS(16), .KEY_BITS(32)) req_chan ();
   bmh_rsp_if #(.COORD_BITS(16), .KEY_BITS(32), .CNT_BITS(11)) rsp_chan ();

   binary_min_heap_priority_queue #(
      .CAPACITY(CAP), .COORD_BITS(16), .KEY_BITS(32)
   ) u_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   heap_req_t pending_reqs[$];
   heap_rpt_t expected_rpts[$];
   logic [31:0] heap_pos[CAP];
   logic [63:0] heap_key[CAP];
   int          heap_fill = 0;
   int  mismatches = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_cnt = 0;
   bit  hold_go = 1'b0;
   bit  hold_used = 1'b0;
   bit  gen_done = 1'b0;

   // clock and reset
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic heap_rpt_t top_report(bit ovf);
      heap_rpt_t r;
      r = '0;
      if (heap_fill != 0) begin
         r.has_entry = 1'b1;
         {r.out_x, r.out_y} = heap_pos[0];
         {r.out_key_primary, r.out_key_secondary} = heap_key[0];
      end
      r.entry_count = heap_fill[10:0];
      r.overflow = ovf;
      return r;
   endfunction

   // heap model: applies one request and returns the report it causes
   function automatic heap_rpt_t heap_apply(heap_req_t q);
      heap_rpt_t r;
      logic [31:0] tp;
      logic [63:0] tk, nk;
      int i, par, lft, rgt, best;
      r = '0;
      case (q.req_type)
         REQ_PUSH: begin
            if (heap_fill >= CAP) return top_report(1'b1);
            nk = {q.key_primary, q.key_secondary};
            i = heap_fill;
            while (i != 0 && nk < heap_key[(i - 1) / 2]) begin
               par = (i - 1) / 2;
               heap_pos[i] = heap_pos[par];
               heap_key[i] = heap_key[par];
               i = par;
            end
            heap_pos[i] = {q.cell_x, q.cell_y};
            heap_key[i] = nk;
            heap_fill++;
            return top_report(1'b0);
         end
         REQ_POP: begin
            if (heap_fill == 0) return top_report(1'b0);
            tp = heap_pos[0];
            tk = heap_key[0];
            heap_fill--;
            heap_pos[0] = heap_pos[heap_fill];
            heap_key[0] = heap_key[heap_fill];
            i = 0;
            forever begin
               lft = 2 * i + 1;
               rgt = 2 * i + 2;
               best = i;
               if (lft < heap_fill && heap_key[lft] < heap_key[best]) best = lft;
               if (rgt < heap_fill && heap_key[rgt] < heap_key[best]) best = rgt;
               if (best == i) break;
               {heap_pos[i], heap_pos[best]} = {heap_pos[best], heap_pos[i]};
               {heap_key[i], heap_key[best]} = {heap_key[best], heap_key[i]};
               i = best;
            end
            r.has_entry = 1'b1;
            {r.out_x, r.out_y} = tp;
            {r.out_key_primary, r.out_key_secondary} = tk;
            r.entry_count = heap_fill[10:0];
            return r;
         end
         REQ_CLEAR: begin
            heap_fill = 0;
            return top_report(1'b0);
         end
         default: return top_report(1'b0);
      endcase
   endfunction

   function automatic heap_req_t mk_req(logic [1:0] t, logic [15:0] x, logic [15:0] y,
                                        logic [31:0] k1, logic [31:0] k2);
      heap_req_t q;
      q.req_type = t;
      q.cell_x = x;
      q.cell_y = y;
      q.key_primary = k1;
      q.key_secondary = k2;
      return q;
   endfunction

   // random request; keys drawn from a narrow range at times to force ties
   function automatic heap_req_t rand_req(int push_pct);
      heap_req_t q;
      int roll;
      q = mk_req(REQ_PUSH, 16'($urandom), 16'($urandom), $urandom, $urandom);
      if ($urandom_range(0, 2) == 0) begin
         q.key_primary = $urandom_range(0, 3);
         q.key_secondary = $urandom_range(0, 3);
      end else if ($urandom_range(0, 9) == 0) begin
         q.key_primary = 32'hFFFF_FFFF;
      end
      roll = $urandom_range(0, 99);
      if (roll >= push_pct) q.req_type = (roll >= 97) ? REQ_UNUSED
                                       : (roll >= 95) ? REQ_CLEAR : REQ_POP;
      return q;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rpts.size() != 0 || req_chan.valid)
         @(posedge clock);
   endtask

   // stimulus
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      // directed: empty cases, extremes, ties, unused code
      pending_reqs.push_back(mk_req(REQ_POP, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, '1, '1));
      pending_reqs.push_back(mk_req(REQ_PUSH, 16'hFFFF, 16'hFFFF, '1, '1));
      pending_reqs.push_back(mk_req(REQ_PUSH, 0, 0, '1, 0));
      pending_reqs.push_back(mk_req(REQ_PUSH, 16'h1234, 16'h5678, '1, 0));
      pending_reqs.push_back(mk_req(REQ_PUSH, 16'hAAAA, 16'h5555, 0, '1));
      pending_reqs.push_back(mk_req(REQ_PUSH, 16'h5555, 16'hAAAA, 0, 0));
      pending_reqs.push_back(mk_req(REQ_UNUSED, 0, 0, 0, 0));
      for (int k = 0; k < 7; k++) pending_reqs.push_back(mk_req(REQ_POP, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_PUSH, 1, 2, 5, 5));
      pending_reqs.push_back(mk_req(REQ_PUSH, 3, 4, 5, 5));
      pending_reqs.push_back(mk_req(REQ_CLEAR, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_POP, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_PUSH, 7, 7, 1, 1));
      pending_reqs.push_back(mk_req(REQ_POP, 0, 0, 0, 0));
      wait_drained();
      // four idling phases of random traffic
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 19 : 81) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 19 : 81) : 0;
         for (int k = 0; k < 150; k++) begin
            pending_reqs.push_back(rand_req((k < 75) ? 65 : 40));
            if (k == 40 && ph == 0) hold_go = 1'b1;
            if (pending_reqs.size() > 8) @(posedge clock);
         end
         wait_drained();
      end
      // build a deeper heap, then drain most of it with pops
      send_idle_pct = 0;
      recv_stall_pct = 19;
      pending_reqs.push_back(mk_req(REQ_CLEAR, 0, 0, 0, 0));
      for (int k = 0; k < 100; k++) pending_reqs.push_back(rand_req(100));
      for (int k = 0; k < 80; k++) pending_reqs.push_back(mk_req(REQ_POP, 0, 0, 0, 0));
      wait_drained();
      gen_done = 1'b1;
   end

   // driver
   always @(posedge clock) begin
      heap_req_t q;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.req_type <= REQ_PUSH;
         {req_chan.cell_x, req_chan.cell_y} <= '0;
         {req_chan.key_primary, req_chan.key_secondary} <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) expected_rpts.push_back(heap_apply({req_chan.req_type,
            req_chan.cell_x, req_chan.cell_y, req_chan.key_primary, req_chan.key_secondary}));
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            q = pending_reqs.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.req_type <= q.req_type;
            req_chan.cell_x <= q.cell_x;
            req_chan.cell_y <= q.cell_y;
            req_chan.key_primary <= q.key_primary;
            req_chan.key_secondary <= q.key_secondary;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response ready with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_cnt <= 0;
         hold_used <= 1'b0;
      end else if (hold_go && !hold_used) begin
         hold_used <= 1'b1;
         hold_cnt <= 300;
         rsp_chan.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      heap_rpt_t got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.has_entry, rsp_chan.out_x, rsp_chan.out_y,
                rsp_chan.out_key_primary, rsp_chan.out_key_secondary,
                rsp_chan.entry_count, rsp_chan.overflow};
         if (expected_rpts.size() == 0) begin
            $display("%t unexpected report: actual %h", $time, got);
            mismatches++;
         end else begin
            want = expected_rpts.pop_front();
            if (got !== want) begin
               $display("%t report mismatch: expected %h actual %h", $time, want, got);
               mismatches++;
            end
         end
      end
   end

   // end of run and cycle limit
   initial begin
      int cyc;
      cyc = 0;
      while (!gen_done && cyc < MAX_CYCLE) begin
         @(posedge clock);
         cyc++;
      end
      if (!gen_done) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         repeat (60) @(posedge clock);
         if (mismatches == 0 && expected_rpts.size() == 0) begin
            $display("end of test: clean");
         end else begin
            $display("end of test: mismatches");
         end
         $finish;
      end
   end

endmodule
